>>> src/hbd_pkg.sv
// shared types, register defaults and stream layout for the h-bridge drive block
package hbd_pkg;

  // encoder counter width default
  localparam int ENC_BITS_DEF = 16;

  // stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_W  = 40;
  localparam int OUT_W = 72;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ON_THR   = 3'd0,
    REG_OFF_THR  = 3'd1,
    REG_MIN_EFF  = 3'd2,
    REG_FULL_EFF = 3'd3,
    REG_PERIOD   = 3'd4
  } reg_idx_t;

  // register reset values
  localparam logic [14:0] ON_THR_RST   = 15'd614;
  localparam logic [14:0] OFF_THR_RST  = 15'd102;
  localparam logic [14:0] MIN_EFF_RST  = 15'd3072;
  localparam logic [14:0] FULL_EFF_RST = 15'd20480;
  localparam logic [15:0] PERIOD_RST   = 16'd999;

  // direction codes
  typedef logic signed [1:0] dir_t;
  localparam dir_t DIR_OFF = 2'sb00;
  localparam dir_t DIR_POS = 2'sb01;
  localparam dir_t DIR_NEG = 2'sb11;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic commit;
  } hbd_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } hbd_stat_t;

endpackage

>>> src/hbd_ctrl.sv
// sequencing state machine for the h-bridge drive block
module hbd_ctrl import hbd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  hbd_stat_t stat,
  output hbd_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

>>> src/hbd_datapath.sv
// registers, unwrap, hysteresis, serial divider and output register
module hbd_datapath import hbd_pkg::*; #(
  parameter int ENCODER_BITS = ENC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  hbd_cmd_t              cmd,
  output hbd_stat_t             stat,
  input  logic [IN_W-1:0]       in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int PROD_W = 32;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int DW     = 34;
  localparam logic [15:0] ENC_MASK =
    (ENCODER_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ENCODER_BITS) - 32'd1);
  localparam logic signed [DW-1:0] MODULUS = 34'sd1 <<< ENCODER_BITS;
  localparam logic signed [DW-1:0] HALF    = (34'sd1 <<< (ENCODER_BITS - 1)) - 34'sd1;
  localparam logic signed [DW-1:0] POS_MAX = 34'sd2147483647;
  localparam logic signed [DW-1:0] POS_MIN = -34'sd2147483648;

  // configuration
  logic [14:0] on_thr, off_thr, min_eff, full_eff;
  logic [15:0] period;

  always_ff @(posedge clk) begin
    if (rst) begin
      on_thr   <= ON_THR_RST;
      off_thr  <= OFF_THR_RST;
      min_eff  <= MIN_EFF_RST;
      full_eff <= FULL_EFF_RST;
      period   <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ON_THR:   on_thr   <= cfg_data[14:0];
        REG_OFF_THR:  off_thr  <= cfg_data[14:0];
        REG_MIN_EFF:  min_eff  <= cfg_data[14:0];
        REG_FULL_EFF: full_eff <= cfg_data[14:0];
        REG_PERIOD:   period   <= cfg_data;
        default: ;
      endcase
    end
  end

  // item registers
  logic [15:0]        raw;
  logic signed [15:0] eff;
  logic               lim;
  logic [15:0]        mag;
  logic signed [DW-1:0] delta;
  dir_t               dir_new;

  // persistent state
  logic [15:0]        last_count;
  logic signed [31:0] position_acc;
  dir_t               dir_mode;
  dir_t               last_direction;

  // divider
  logic [PROD_W-1:0] dvd;
  logic [14:0]       rem;
  logic [CNT_W-1:0]  cnt;

  // magnitude and divisor
  logic [15:0] mag_c;
  logic [14:0] full_c;
  assign mag_c  = eff[15] ? 16'(-eff) : 16'(eff);
  assign full_c = (full_eff == 15'd0) ? 15'd1 : full_eff;

  // unwrap
  logic signed [DW-1:0] d0, d1, d2;
  always_comb begin
    d0 = $signed({18'd0, raw}) - $signed({18'd0, last_count});
    d1 = (d0 > HALF) ? d0 - MODULUS : d0;
    d2 = (d1 < -HALF) ? d1 + MODULUS : d1;
  end

  // direction hysteresis
  logic signed [16:0] u17, on17, off17;
  dir_t dir_h;
  always_comb begin
    u17   = {eff[15], eff};
    on17  = {2'b00, on_thr};
    off17 = {2'b00, off_thr};
    dir_h = dir_mode;
    unique case (dir_mode)
      DIR_OFF: begin
        if (u17 > on17) dir_h = DIR_POS;
        else if (u17 < -on17) dir_h = DIR_NEG;
      end
      DIR_POS: if (u17 < off17) dir_h = DIR_OFF;
      default: if (u17 > -off17) dir_h = DIR_OFF;
    endcase
  end

  // restoring divide step
  logic [15:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem, dvd[PROD_W-1]};
  assign ge     = rem_sh >= {1'b0, full_c};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw <= in_data[15:0] & ENC_MASK;
      eff <= $signed(in_data[31:16]);
      lim <= in_data[32];
    end
    if (cmd.mul) begin
      mag     <= mag_c;
      dvd     <= {16'd0, mag_c} * {16'd0, period};
      rem     <= '0;
      delta   <= d2;
      dir_new <= dir_h;
    end
    if (cmd.div_step) begin
      rem <= ge ? 15'(rem_sh - {1'b0, full_c}) : rem_sh[14:0];
      dvd <= {dvd[PROD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mul) begin
      cnt <= '0;
    end else if (cmd.div_step) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // final result
  logic [15:0]          q_cap, cmp, cmp_fin;
  logic signed [DW-1:0] pos_sum;
  logic signed [31:0]   pos_sat, pos_fin;
  logic                 home, dead;
  dir_t                 dir_fin;
  always_comb begin
    q_cap   = (dvd > {16'd0, period}) ? period : dvd[15:0];
    cmp     = (mag < {1'b0, min_eff}) ? 16'd0 : q_cap;
    pos_sum = $signed({{2{position_acc[31]}}, position_acc}) + delta;
    if (pos_sum > POS_MAX)      pos_sat = 32'sh7FFFFFFF;
    else if (pos_sum < POS_MIN) pos_sat = 32'sh80000000;
    else                        pos_sat = pos_sum[31:0];
    home    = lim && (dir_new == DIR_POS);
    dir_fin = home ? DIR_OFF : dir_new;
    pos_fin = home ? 32'sd0 : pos_sat;
    cmp_fin = (dir_fin == DIR_OFF) ? 16'd0 : cmp;
    dead    = (dir_fin != last_direction) && (dir_fin != DIR_OFF)
              && (last_direction != DIR_OFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_count     <= '0;
      position_acc   <= '0;
      dir_mode       <= DIR_OFF;
      last_direction <= DIR_OFF;
      m_tvalid       <= 1'b0;
    end else if (cmd.commit) begin
      last_count     <= raw;
      position_acc   <= pos_fin;
      dir_mode       <= dir_fin;
      last_direction <= dir_fin;
      m_tvalid       <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_tdata <= {4'd0, pos_fin, home, dead, dir_fin,
                  (dir_fin == DIR_NEG) ? cmp_fin : 16'd0,
                  (dir_fin == DIR_POS) ? cmp_fin : 16'd0};
    end
  end

  assign stat.div_last = (cnt == CNT_W'(PROD_W - 1));
  assign stat.out_busy = m_tvalid && !m_tready;

endmodule

>>> src/hbridge_drive_with_direction_hysteresis.sv
// top level of the h-bridge drive stage with direction hysteresis
// One beat in per sample tick gives one beat out. Each tick the encoder
// counter delta is unwrapped into a saturating signed position, the
// compare value is floor(|effort| * pwm_period / full_scale_effort) capped
// at pwm_period (zero below min_active_effort or with direction off), and
// a three-state hysteresis on the effort picks the bridge leg. Hitting the
// limit switch while moving positive stops the drive, clears the position
// and raises home_hit; a reversal between two driven directions raises
// dead_time_first. An item goes from input beat to output beat through
// capture, the 16x16 product, the one-bit-per-cycle restoring divider and
// a commit that waits for a free output register. The next input beat is
// taken once the result is in the output register, though not yet taken.
// Configuration writes are only legal while the block is idle.
module hbridge_drive_with_direction_hysteresis import hbd_pkg::*; #(
  parameter int ENCODER_BITS = ENC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // input beat
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,  // encoder_count[15:0], effort[31:16], limit_pressed[32]
  // result beat
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,  // pos_leg_compare[15:0], neg_leg_compare[31:16],
                                          // direction[33:32], dead_time_first[34],
                                          // home_hit[35], position[67:36]
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hbd_cmd_t  cmd;
  hbd_stat_t stat;

  // controller: capture, multiply, divide loop, commit
  hbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: registers, unwrap, hysteresis, divider, output register
  hbd_datapath #(
    .ENCODER_BITS (ENCODER_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // one item in flight: an accepted beat closes the input
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // at most one bridge leg carries a compare value
  a_one_leg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[15:0] == 16'd0 || m_tdata[31:16] == 16'd0))
    else $error("both legs driven");

  // home stops the drive and clears the position
  a_home: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[35]) |->
      (m_tdata[33:32] == 2'b00 && m_tdata[67:36] == 32'd0 && !m_tdata[34]))
    else $error("home beat with drive or position");

  // dead time only on a driven direction
  a_dead: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[34]) |-> (m_tdata[33:32] == 2'b01 || m_tdata[33:32] == 2'b11))
    else $error("dead time flagged with direction off");
`endif

endmodule

>>> test/tb_hbridge_drive_with_direction_hysteresis.sv
// testbench for the h-bridge drive stage: directed and random sample ticks against a predictor
module tb_hbridge_drive_with_direction_hysteresis;
  import hbd_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 40;     // drain margin for an item still in flight
  localparam int ENC_MOD      = 1 << ENC_BITS_DEF;
  localparam int ENC_HALF     = (ENC_MOD / 2) - 1;
  localparam int POS_MAX      = 32'h7fff_ffff;
  localparam int POS_MIN      = 32'h8000_0000;

  // indexes outside the register map, writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // one result beat, unpacked
  typedef struct packed {
    logic [15:0]        pos_cmp;
    logic [15:0]        neg_cmp;
    dir_t               dir;
    logic               dead;
    logic               home;
    logic signed [31:0] position;
  } drive_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the drive state
  logic [14:0]        on_thr   = ON_THR_RST;
  logic [14:0]        off_thr  = OFF_THR_RST;
  logic [14:0]        min_eff  = MIN_EFF_RST;
  logic [14:0]        full_eff = FULL_EFF_RST;
  logic [15:0]        period   = PERIOD_RST;
  logic [15:0]        enc_last = '0;
  int                 pos_acc  = 0;
  dir_t               mode     = DIR_OFF;
  dir_t               last_dir = DIR_OFF;

  drive_t pending_drive[$];
  int     mismatches     = 0;
  int     cycles         = 0;
  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;

  hbridge_drive_with_direction_hysteresis dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_drive.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // one sample tick: unwrap, position, duty, hysteresis, home
  function automatic drive_t predict_drive(logic [15:0] cnt, logic signed [15:0] eff, logic lim);
    drive_t r;
    longint d, p, c, m, pr, f, mn;
    int     u, last_i, on_i, off_i;
    dir_t   dir;
    u = eff;
    last_i = enc_last;
    d = cnt;
    d = d - last_i;
    if (d > ENC_HALF) d = d - ENC_MOD;
    if (d < -ENC_HALF) d = d + ENC_MOD;
    enc_last = cnt;
    p = pos_acc;
    p = p + d;
    if (p > POS_MAX) p = POS_MAX;
    if (p < POS_MIN) p = POS_MIN;
    pos_acc = int'(p);

    m = (u < 0) ? -u : u;
    pr = period;
    f = full_eff;
    if (f == 0) f = 1;          // zero full scale behaves as one
    mn = min_eff;
    c = (m * pr) / f;
    if (c > pr) c = pr;
    if (m < mn) c = 0;

    // three-state hysteresis, a direction always ends through off
    on_i = on_thr;
    off_i = off_thr;
    if (mode == DIR_OFF) begin
      if (u > on_i) mode = DIR_POS;
      else if (u < -on_i) mode = DIR_NEG;
    end else if (mode == DIR_POS) begin
      if (u < off_i) mode = DIR_OFF;
    end else begin
      if (u > -off_i) mode = DIR_OFF;
    end
    dir = mode;

    r.home = 1'b0;
    if (lim && dir == DIR_POS) begin
      dir = DIR_OFF;
      mode = DIR_OFF;
      c = 0;
      pos_acc = 0;
      r.home = 1'b1;
    end
    if (dir == DIR_OFF) c = 0;

    r.dead = (dir != last_dir) && (dir != DIR_OFF) && (last_dir != DIR_OFF);
    last_dir = dir;
    r.pos_cmp = (dir == DIR_POS) ? c[15:0] : 16'd0;
    r.neg_cmp = (dir == DIR_NEG) ? c[15:0] : 16'd0;
    r.dir = dir;
    r.position = pos_acc;
    return r;
  endfunction

  function automatic void note_mismatch(string what, drive_t want, drive_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("%s: want pos %0d neg %0d dir %0d dead %0b home %0b position %0d, ",
             what, want.pos_cmp, want.neg_cmp, want.dir, want.dead, want.home,
             want.position);
      $display("got pos %0d neg %0d dir %0d dead %0b home %0b position %0d",
               got.pos_cmp, got.neg_cmp, got.dir, got.dead, got.home, got.position);
    end
  endfunction

  // result side: check each accepted beat, then pick the next ready value
  always @(posedge clk) begin : result_check
    drive_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.pos_cmp  = m_tdata[15:0];
      got.neg_cmp  = m_tdata[31:16];
      got.dir      = m_tdata[33:32];
      got.dead     = m_tdata[34];
      got.home     = m_tdata[35];
      got.position = m_tdata[67:36];
      if (pending_drive.size() == 0) begin
        note_mismatch("result beat with nothing expected", '0, got);
      end else begin
        want = pending_drive.pop_front();
        if (got.pos_cmp !== want.pos_cmp || got.neg_cmp !== want.neg_cmp ||
            got.dir !== want.dir || got.dead !== want.dead ||
            got.home !== want.home || got.position !== want.position)
          note_mismatch("result mismatch", want, got);
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // one input beat; valid stays high after the beat until the next call or a drain
  task automatic send_sample(logic [15:0] cnt, logic signed [15:0] eff, logic lim);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, lim, eff, cnt};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_drive.push_back(predict_drive(cnt, eff, lim));
  endtask

  // stop sending and wait for every outstanding result, then the latency
  task automatic wait_drive_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ON_THR:   on_thr   = data[14:0];
      REG_OFF_THR:  off_thr  = data[14:0];
      REG_MIN_EFF:  min_eff  = data[14:0];
      REG_FULL_EFF: full_eff = data[14:0];
      REG_PERIOD:   period   = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(int on_v, int off_v, int min_v, int full_v, int per_v);
    write_reg(REG_ON_THR, on_v[15:0]);
    write_reg(REG_OFF_THR, off_v[15:0]);
    write_reg(REG_MIN_EFF, min_v[15:0]);
    write_reg(REG_FULL_EFF, full_v[15:0]);
    write_reg(REG_PERIOD, per_v[15:0]);
  endtask

  // reset registers: threshold edges, hysteresis hold, duty cap and minimum effort
  task automatic test_default_thresholds();
    send_sample(16'd0, 16'sd614, 1'b0);     // equal to on threshold, stays off
    send_sample(16'd10, 16'sd615, 1'b0);    // starts positive, duty below minimum
    send_sample(16'd20, 16'sh7fff, 1'b0);   // duty capped at the period
    send_sample(16'd30, 16'sd101, 1'b0);    // below off threshold, ends
    send_sample(16'd40, -16'sd615, 1'b0);   // starts negative
    send_sample(16'd50, 16'sh8000, 1'b0);   // most negative effort
    send_sample(16'd40, -16'sd102, 1'b0);   // on the off threshold, holds
    send_sample(16'd30, -16'sd101, 1'b0);   // ends
    send_sample(16'd30, 16'sd3072, 1'b0);   // right at minimum effort
  endtask

  // counter deltas at and around half the counter range, and wrap in both ways
  task automatic test_encoder_unwrap();
    send_sample(16'd32797, 16'sd0, 1'b0);
    send_sample(16'd30, 16'sd0, 1'b0);
    send_sample(16'd32798, 16'sd0, 1'b0);
    send_sample(16'd30, 16'sd0, 1'b0);
    send_sample(16'hffff, 16'sd0, 1'b0);
    send_sample(16'h0000, 16'sd0, 1'b0);
  endtask

  // limit switch: only a positive move homes
  task automatic test_home_switch();
    send_sample(16'd100, 16'sd5000, 1'b1);
    send_sample(16'd200, -16'sd5000, 1'b1);
    send_sample(16'd200, 16'sd0, 1'b1);
    send_sample(16'd300, 16'sd5000, 1'b0);
    send_sample(16'd350, 16'sd5000, 1'b1);
  endtask

  // register extremes, zero full scale, masked data and spare indexes
  task automatic test_register_extremes();
    wait_drive_idle();
    write_all_regs(0, 0, 0, 0, 16'hffff);
    send_sample(16'd400, 16'sd1, 1'b0);
    send_sample(16'd410, 16'sd0, 1'b0);
    send_sample(16'd420, -16'sd1, 1'b0);
    wait_drive_idle();
    write_all_regs(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 1);
    write_reg(REG_SPARE_LO, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hffff);
    send_sample(16'd430, 16'sh7fff, 1'b0);
    send_sample(16'd440, 16'sh8000, 1'b0);
    send_sample(16'd450, -16'sd32767, 1'b0);
  endtask

  // random ticks over several register settings and idle patterns
  task automatic test_random_traffic();
    int sel, e, base, prev_e, on_v;
    logic [15:0] cnt;
    logic lim;
    prev_e = 0;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drive_idle();
      case ((phase / 2) % 4)
        0: write_all_regs(2000, 500, 100, 8000, 1234);
        1: write_all_regs(0, 0, 0, 1, 65535);
        2: begin
          on_v = $urandom_range(0, 4000);
          write_all_regs(on_v, $urandom_range(0, on_v), $urandom_range(0, 8000),
                         $urandom_range(1, 32767), $urandom_range(1, 65535));
        end
        default: write_all_regs(ON_THR_RST, OFF_THR_RST, MIN_EFF_RST, FULL_EFF_RST,
                                PERIOD_RST);
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < 128; n++) begin
        // hold off once per phase until the pipe is empty
        if (n == 64) wait_drive_idle();
        sel = $urandom_range(99);
        if (sel < 70) cnt = 16'(enc_last + $urandom_range(0, 400) - 200);
        else if (sel < 90) cnt = 16'($urandom);
        else if ($urandom_range(1)) cnt = 16'(enc_last + 32766 + $urandom_range(0, 4));
        else cnt = 16'(enc_last - 32766 - $urandom_range(0, 4));

        sel = $urandom_range(99);
        if (sel < 30) begin
          e = $signed(16'($urandom));
        end else if (sel < 60) begin
          // hover around a threshold to hit the hysteresis edges
          case ($urandom_range(3))
            0: base = on_thr;
            1: base = off_thr;
            2: base = min_eff;
            default: base = full_eff;
          endcase
          e = base + $urandom_range(0, 6) - 3;
          if ($urandom_range(1)) e = -e;
        end else if (sel < 85) begin
          e = prev_e + $urandom_range(0, 600) - 300;
        end else begin
          e = $urandom_range(0, 2 * int'(full_eff)) - int'(full_eff);
        end
        if (e > 32767) e = 32767;
        if (e < -32768) e = -32768;
        prev_e = e;
        lim = ($urandom_range(99) < 12);
        send_sample(cnt, e[15:0], lim);
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_default_thresholds();
    test_encoder_unwrap();
    test_home_switch();
    test_register_extremes();
    test_random_traffic();
    wait_drive_idle();
    if (mismatches == 0 && pending_drive.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
